// ===== rtl/core/gpthv_pkg.sv =====
// Shared types, constants and helper functions for the GPT header validator.
// Has no dependencies; every other file in rtl/core refers to it by scoped names.
package gpthv_pkg;

  // "EFI PART" read as a little-endian 64-bit word.
  localparam logic [63:0] GPT_SIGNATURE = 64'h5452415020494645;
  localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES      = 32'hFFFFFFFF;
  localparam logic [31:0] MIN_HEADER    = 32'd92;
  localparam logic [12:0] COUNT_MAX     = 13'h1FFF;

  // Configuration port.
  localparam int unsigned   CFG_ADDR_W         = 3;
  localparam logic [12:0]   SECTOR_BYTES_RESET = 13'd512;
  // Register index, taken from paddr[2] (registers sit on 4-byte boundaries).
  localparam logic          REG_SECTOR_BYTES   = 1'b0;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_BAD_SIG   = 3'd2,
    ST_BAD_SIZE  = 3'd3,
    ST_CRC_BAD   = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } sec_item_t;

  typedef struct packed {
    logic        header_ok;
    status_t     status;
    logic [63:0] hdr_lba;
    logic [63:0] alt_lba;
    logic [63:0] usable_start;
    logic [63:0] usable_end;
    logic [63:0] parts_lba;
    logic [31:0] parts_count;
    logic [31:0] parts_size;
    logic [31:0] table_crc;
  } res_item_t;

  // One byte of a reflected CRC-32, bit by bit.
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  // Replace byte lane 'lane' of a 64-bit word.
  function automatic logic [63:0] put_byte64(input logic [63:0] w, input logic [7:0] b,
                                             input logic [2:0] lane);
    logic [63:0] r;
    r = w;
    r[{lane, 3'b000} +: 8] = b;
    return r;
  endfunction

  // Replace byte lane 'lane' of a 32-bit word.
  function automatic logic [31:0] put_byte32(input logic [31:0] w, input logic [7:0] b,
                                             input logic [1:0] lane);
    logic [31:0] r;
    r = w;
    r[{lane, 3'b000} +: 8] = b;
    return r;
  endfunction

endpackage

// ===== rtl/core/gpt_header_validator.sv =====
// Top level of the GPT header validator: byte channel, result channel, APB register.
// Depends on gpthv_pkg and instantiates gpthv_crc.

// The block takes the sector holding a GPT header one byte per transaction on the
// sec channel, starting at offset zero, with last_byte set on the final byte. Each
// transaction is registered once at the input and handled from there, so a new
// byte is accepted in every cycle unless a final byte waits; the byte-wise CRC-32
// update, header field capture and final checks form that stage. On the final byte a
// single result transaction is presented on the res channel from an output
// register: status is checked in the order sector size over MAX_SECTOR_BYTES, bad
// "EFI PART" signature, header size below 92, above sector_bytes or above the
// bytes received, and CRC mismatch. On success the decoded LBAs, the entry count,
// the entry size and the table CRC are given; otherwise they read as zero. While
// a result waits to be taken, bytes of the next sector keep flowing; only a
// further final byte stalls until the pending result leaves. The per-sector state
// returns to its reset value after each final byte. sector_bytes sits at APB byte
// address 0 and should be written only between sectors.
module gpt_header_validator #(
  parameter int unsigned MAX_SECTOR_BYTES = 512
) (
  input  logic                              clk,
  input  logic                              rst,
  // Sector byte channel.
  input  logic                              sec_valid,
  output logic                              sec_ready,
  input  gpthv_pkg::sec_item_t              sec_item,
  // Result channel.
  output logic                              res_valid,
  input  logic                              res_ready,
  output gpthv_pkg::res_item_t              res_item,
  // APB configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gpthv_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  // Configuration register.
  logic [12:0] sector_bytes;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == gpthv_pkg::REG_SECTOR_BYTES) ? {19'd0, sector_bytes} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sector_bytes <= gpthv_pkg::SECTOR_BYTES_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == gpthv_pkg::REG_SECTOR_BYTES)) begin
      sector_bytes <= pwdata[12:0];
    end
  end

  // Input register. The stage moves on whenever its byte is not the final one, or
  // when the output register is free or being emptied in this cycle.
  logic                 s1_valid;
  gpthv_pkg::sec_item_t s1_item;
  logic                 s1_go;

  assign s1_go     = s1_valid && (!s1_item.last_byte || !res_valid || res_ready);
  assign sec_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sec_ready) begin
      s1_valid <= sec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sec_valid && sec_ready) begin
      s1_item <= sec_item;
    end
  end

  // Per-sector state.
  logic [12:0] byte_count;
  logic [63:0] signature_word;
  logic [31:0] header_length;
  logic [31:0] stored_crc;
  logic [63:0] hdr_lba;
  logic [63:0] alt_lba;
  logic [63:0] usable_start;
  logic [63:0] usable_end;
  logic [63:0] parts_lba;
  logic [31:0] parts_count;
  logic [31:0] parts_size;
  logic [31:0] table_crc;

  logic [12:0] byte_count_next;
  logic [63:0] signature_word_next;
  logic [31:0] header_length_next;
  logic [31:0] stored_crc_next;
  logic [63:0] hdr_lba_next;
  logic [63:0] alt_lba_next;
  logic [63:0] usable_start_next;
  logic [63:0] usable_end_next;
  logic [63:0] parts_lba_next;
  logic [31:0] parts_count_next;
  logic [31:0] parts_size_next;
  logic [31:0] table_crc_next;
  logic [31:0] crc_next;

  logic [12:0] off;
  logic [7:0]  b;

  assign off = byte_count;
  assign b   = s1_item.data_byte;

  // Capture the little-endian header fields as their bytes pass. Every field
  // starts on a boundary of its own width, so the byte lane is the low bits of
  // the offset.
  always_comb begin
    signature_word_next = signature_word;
    header_length_next  = header_length;
    stored_crc_next     = stored_crc;
    hdr_lba_next        = hdr_lba;
    alt_lba_next        = alt_lba;
    usable_start_next   = usable_start;
    usable_end_next     = usable_end;
    parts_lba_next      = parts_lba;
    parts_count_next    = parts_count;
    parts_size_next     = parts_size;
    table_crc_next      = table_crc;

    if (off < 13'd8) begin
      signature_word_next = gpthv_pkg::put_byte64(signature_word, b, off[2:0]);
    end else if (off >= 13'd12 && off < 13'd16) begin
      header_length_next = gpthv_pkg::put_byte32(header_length, b, off[1:0]);
    end else if (off >= 13'd16 && off < 13'd20) begin
      stored_crc_next = gpthv_pkg::put_byte32(stored_crc, b, off[1:0]);
    end else if (off >= 13'd24 && off < 13'd32) begin
      hdr_lba_next = gpthv_pkg::put_byte64(hdr_lba, b, off[2:0]);
    end else if (off >= 13'd32 && off < 13'd40) begin
      alt_lba_next = gpthv_pkg::put_byte64(alt_lba, b, off[2:0]);
    end else if (off >= 13'd40 && off < 13'd48) begin
      usable_start_next = gpthv_pkg::put_byte64(usable_start, b, off[2:0]);
    end else if (off >= 13'd48 && off < 13'd56) begin
      usable_end_next = gpthv_pkg::put_byte64(usable_end, b, off[2:0]);
    end else if (off >= 13'd72 && off < 13'd80) begin
      parts_lba_next = gpthv_pkg::put_byte64(parts_lba, b, off[2:0]);
    end else if (off >= 13'd80 && off < 13'd84) begin
      parts_count_next = gpthv_pkg::put_byte32(parts_count, b, off[1:0]);
    end else if (off >= 13'd84 && off < 13'd88) begin
      parts_size_next = gpthv_pkg::put_byte32(parts_size, b, off[1:0]);
    end else if (off >= 13'd88 && off < 13'd92) begin
      table_crc_next = gpthv_pkg::put_byte32(table_crc, b, off[1:0]);
    end
  end

  // The counter sticks at its maximum on overlong sectors.
  assign byte_count_next = (byte_count < gpthv_pkg::COUNT_MAX) ? byte_count + 13'd1 : byte_count;

  gpthv_crc u_crc (
    .clk           (clk),
    .rst           (rst),
    .go            (s1_go),
    .clear         (s1_item.last_byte),
    .data_byte     (b),
    .offset        (off),
    .header_length (header_length),
    .crc_next      (crc_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      signature_word <= '0;
      header_length  <= '0;
      stored_crc     <= '0;
      hdr_lba        <= '0;
      alt_lba        <= '0;
      usable_start   <= '0;
      usable_end     <= '0;
      parts_lba      <= '0;
      parts_count    <= '0;
      parts_size     <= '0;
      table_crc      <= '0;
    end else if (s1_go) begin
      if (s1_item.last_byte) begin
        byte_count     <= '0;
        signature_word <= '0;
        header_length  <= '0;
        stored_crc     <= '0;
        hdr_lba        <= '0;
        alt_lba        <= '0;
        usable_start   <= '0;
        usable_end     <= '0;
        parts_lba      <= '0;
        parts_count    <= '0;
        parts_size     <= '0;
        table_crc      <= '0;
      end else begin
        byte_count     <= byte_count_next;
        signature_word <= signature_word_next;
        header_length  <= header_length_next;
        stored_crc     <= stored_crc_next;
        hdr_lba        <= hdr_lba_next;
        alt_lba        <= alt_lba_next;
        usable_start   <= usable_start_next;
        usable_end     <= usable_end_next;
        parts_lba      <= parts_lba_next;
        parts_count    <= parts_count_next;
        parts_size     <= parts_size_next;
        table_crc      <= table_crc_next;
      end
    end
  end

  // Final checks, made on the state as it stands after the final byte.
  logic [13:0]          received;
  gpthv_pkg::status_t   status;
  gpthv_pkg::res_item_t result;

  assign received = {1'b0, off} + 14'd1;

  always_comb begin
    if (sector_bytes > 13'(MAX_SECTOR_BYTES)) begin
      status = gpthv_pkg::ST_TOO_LARGE;
    end else if (signature_word_next != gpthv_pkg::GPT_SIGNATURE) begin
      status = gpthv_pkg::ST_BAD_SIG;
    end else if (header_length_next < gpthv_pkg::MIN_HEADER ||
                 header_length_next > {19'd0, sector_bytes} ||
                 header_length_next > {18'd0, received}) begin
      status = gpthv_pkg::ST_BAD_SIZE;
    end else if ((crc_next ^ gpthv_pkg::CRC_ONES) != stored_crc_next) begin
      status = gpthv_pkg::ST_CRC_BAD;
    end else begin
      status = gpthv_pkg::ST_OK;
    end

    result           = '0;
    result.status    = status;
    result.header_ok = (status == gpthv_pkg::ST_OK);
    if (status == gpthv_pkg::ST_OK) begin
      result.hdr_lba      = hdr_lba_next;
      result.alt_lba      = alt_lba_next;
      result.usable_start = usable_start_next;
      result.usable_end   = usable_end_next;
      result.parts_lba    = parts_lba_next;
      result.parts_count  = parts_count_next;
      result.parts_size   = parts_size_next;
      result.table_crc    = table_crc_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_go && s1_item.last_byte) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_item.last_byte) begin
      res_item <= result;
    end
  end

  // header_ok always agrees with the status code.
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_item.header_ok == (res_item.status == gpthv_pkg::ST_OK)))
    else $error("header_ok disagrees with status");

  // A failed header never exposes decoded fields.
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_item.status != gpthv_pkg::ST_OK) |->
      (res_item.hdr_lba == 64'd0 && res_item.parts_lba == 64'd0 &&
       res_item.parts_count == 32'd0 && res_item.table_crc == 32'd0))
    else $error("decoded fields reported on a failed header");

  // The final byte of a sector restarts the byte count and raises a result.
  assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_item.last_byte) |=> (byte_count == 13'd0 && res_valid))
    else $error("sector state not restarted after final byte");

  // The per-sector state only moves when the input stage advances.
  assert property (@(posedge clk) disable iff (rst)
    (!rst && !s1_go) |=> $stable(byte_count))
    else $error("byte count changed without an accepted byte");

endmodule

// ===== rtl/core/gpthv_crc.sv =====
// Running reflected CRC-32 over the covered header bytes.
// Depends on gpthv_pkg for the polynomial, the initial value and crc_byte.
module gpthv_crc (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic        clear,
  input  logic [7:0]  data_byte,
  input  logic [12:0] offset,
  input  logic [31:0] header_length,
  output logic [31:0] crc_next
);

  logic [31:0] crc_accum;
  logic        covered;
  logic        in_crc_field;

  // The stored CRC field (offsets 16 to 19) is hashed as zeros.
  assign in_crc_field = (offset >= 13'd16) && (offset < 13'd20);
  assign covered      = (offset < 13'd16) || ({19'd0, offset} < header_length);

  always_comb begin
    crc_next = crc_accum;
    if (covered) begin
      crc_next = gpthv_pkg::crc_byte(crc_accum, in_crc_field ? 8'd0 : data_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_accum <= gpthv_pkg::CRC_ONES;
    end else if (go) begin
      crc_accum <= clear ? gpthv_pkg::CRC_ONES : crc_next;
    end
  end

endmodule
